// ===== sv/tse_pkg.sv =====
// Package for the tab stop expander: character codes, register indexes,
// controller states and the command/status bundles. No dependencies.
package tse_pkg;

  localparam int unsigned ByteBits   = 8;
  localparam int unsigned StopBits   = 16;
  localparam int unsigned RepeatBits = 16;
  localparam int unsigned CfgIdxBits = 3;
  localparam int unsigned ListBits   = 3;

  localparam logic [ByteBits-1:0] CharTab   = 8'h09;
  localparam logic [ByteBits-1:0] CharBs    = 8'h08;
  localparam logic [ByteBits-1:0] CharNl    = 8'h0a;
  localparam logic [ByteBits-1:0] CharSpace = 8'h20;

  localparam logic [StopBits-1:0] DefaultInterval = 16'd8;

  localparam logic [CfgIdxBits-1:0] RegListCount = 3'd0;
  localparam logic [CfgIdxBits-1:0] RegStop0     = 3'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLASSIFY,
    ST_DIVIDE,
    ST_REMAIN,
    ST_SEARCH,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic capture;
    logic classify;
    logic div_step;
    logic div_fix;
    logic search_step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic is_tab;
    logic use_interval;
    logic div_last;
    logic search_done;
    logic out_free;
  } status_t;

endpackage

// ===== sv/tab_stop_expander.sv =====
// Top level of the tab stop expander: register file, controller and
// datapath. Depends on tse_pkg, tse_regs, tse_ctrl and tse_dp.
//
//   channel | direction | handshake            | payload
//   cfg     | in        | cfg_valid_i/ready_o  | cfg_index_i, cfg_data_i
//   in      | in        | in_valid_i/ready_o   | in_byte_i, new_file_i
//   out     | out       | out_valid_o/ready_i  | out_byte_o, repeat_res_o
//
// A non-tab byte goes from acceptance through the classify and finish states to
// its registered result. A tab on interval stops also passes the divide and
// remain states, where the bit-serial remainder of the column is worked out. A
// tab on listed stops passes the search state, one step per list entry examined
// and one more when the list runs out. One byte is worked on at a time.
// Reset clears the column, the stop index and the controller, and sets the registers to their defaults.
// The input is taken again while a result still waits; a new result waits
// in its last step until the output register is free.
module tab_stop_expander #(
  parameter int unsigned COLUMN_BITS = 16,
  parameter int unsigned NUM_STOPS   = 7
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [tse_pkg::CfgIdxBits-1:0]     cfg_index_i,
  input  logic [tse_pkg::StopBits-1:0]       cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [tse_pkg::ByteBits-1:0]       in_byte_i,
  input  logic                               new_file_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [tse_pkg::ByteBits-1:0]       out_byte_o,
  output logic [tse_pkg::RepeatBits-1:0]     repeat_res_o
);

  logic [tse_pkg::ListBits-1:0] list_count;
  logic [tse_pkg::StopBits-1:0] stops [NUM_STOPS];
  tse_pkg::cmd_t                cmd;
  tse_pkg::status_t             status;

  tse_regs #(
    .NUM_STOPS (NUM_STOPS)
  ) u_regs (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .list_count_o (list_count),
    .stops_o      (stops)
  );

  tse_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  tse_dp #(
    .COLUMN_BITS (COLUMN_BITS),
    .NUM_STOPS   (NUM_STOPS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .in_byte_i    (in_byte_i),
    .new_file_i   (new_file_i),
    .list_count_i (list_count),
    .stops_i      (stops),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_byte_o   (out_byte_o),
    .repeat_res_o (repeat_res_o)
  );

  // Only one byte is in flight: an accepted beat closes the input next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while a byte is still in flight");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> repeat_res_o != '0)
    else $error("result with a zero repeat count");

  // Only an expanded tab may carry a run longer than one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_byte_o != tse_pkg::CharSpace |-> repeat_res_o == 16'd1)
    else $error("echoed byte with a repeat count other than one");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.finish |-> !in_ready_o)
    else $error("result loaded while the input is open");

endmodule

// ===== sv/tse_regs.sv =====
// Configuration register file of the tab stop expander: stop count and
// the stop table. Depends on tse_pkg.
module tse_regs #(
  parameter int unsigned NUM_STOPS = 7
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [tse_pkg::CfgIdxBits-1:0]     cfg_index_i,
  input  logic [tse_pkg::StopBits-1:0]       cfg_data_i,
  output logic [tse_pkg::ListBits-1:0]       list_count_o,
  output logic [tse_pkg::StopBits-1:0]       stops_o [NUM_STOPS]
);

  logic [tse_pkg::ListBits-1:0] list_count_q;
  logic [tse_pkg::StopBits-1:0] stops_q [NUM_STOPS];

  // Writes are always taken; an index past the stop table is dropped.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      list_count_q <= '0;
      for (int i = 0; i < NUM_STOPS; i++) begin
        stops_q[i] <= (i == 0) ? tse_pkg::DefaultInterval : '0;
      end
    end else if (cfg_valid_i) begin
      if (cfg_index_i == tse_pkg::RegListCount) begin
        list_count_q <= cfg_data_i[tse_pkg::ListBits-1:0];
      end
      for (int i = 0; i < NUM_STOPS; i++) begin
        if (cfg_index_i == tse_pkg::CfgIdxBits'(i) + tse_pkg::RegStop0) begin
          stops_q[i] <= cfg_data_i;
        end
      end
    end
  end

  assign list_count_o = list_count_q;
  assign stops_o      = stops_q;

endmodule

// ===== sv/tse_ctrl.sv =====
// Controller of the tab stop expander: sequences classify, divide,
// stop search and result hand-off. Depends on tse_pkg.
module tse_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  tse_pkg::status_t status_i,
  output tse_pkg::cmd_t    cmd_o
);

  tse_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tse_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      tse_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = tse_pkg::ST_CLASSIFY;
      end
      tse_pkg::ST_CLASSIFY: begin
        if (!status_i.is_tab) begin
          state_d = tse_pkg::ST_FINISH;
        end else if (status_i.use_interval) begin
          state_d = tse_pkg::ST_DIVIDE;
        end else begin
          state_d = tse_pkg::ST_SEARCH;
        end
      end
      tse_pkg::ST_DIVIDE: begin
        if (status_i.div_last) state_d = tse_pkg::ST_REMAIN;
      end
      tse_pkg::ST_REMAIN: begin
        state_d = tse_pkg::ST_FINISH;
      end
      tse_pkg::ST_SEARCH: begin
        if (status_i.search_done) state_d = tse_pkg::ST_FINISH;
      end
      tse_pkg::ST_FINISH: begin
        if (status_i.out_free) state_d = tse_pkg::ST_IDLE;
      end
      default: begin
        state_d = tse_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      tse_pkg::ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      tse_pkg::ST_CLASSIFY: cmd_o.classify    = 1'b1;
      tse_pkg::ST_DIVIDE:   cmd_o.div_step    = 1'b1;
      tse_pkg::ST_REMAIN:   cmd_o.div_fix     = 1'b1;
      tse_pkg::ST_SEARCH:   cmd_o.search_step = 1'b1;
      tse_pkg::ST_FINISH:   cmd_o.finish      = status_i.out_free;
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

// ===== sv/tse_dp.sv =====
// Datapath of the tab stop expander: column and stop index, a bit-serial
// remainder unit, the stop search and the result register. Depends on tse_pkg.
module tse_dp #(
  parameter int unsigned COLUMN_BITS = 16,
  parameter int unsigned NUM_STOPS   = 7
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  tse_pkg::cmd_t                      cmd_i,
  output tse_pkg::status_t                   status_o,
  input  logic [tse_pkg::ByteBits-1:0]       in_byte_i,
  input  logic                               new_file_i,
  input  logic [tse_pkg::ListBits-1:0]       list_count_i,
  input  logic [tse_pkg::StopBits-1:0]       stops_i [NUM_STOPS],
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [tse_pkg::ByteBits-1:0]       out_byte_o,
  output logic [tse_pkg::RepeatBits-1:0]     repeat_res_o
);

  localparam int unsigned CntBits = $clog2(COLUMN_BITS);
  localparam int unsigned CmpBits = (COLUMN_BITS > tse_pkg::StopBits) ?
                                    COLUMN_BITS : tse_pkg::StopBits;
  localparam int unsigned SumBits = CmpBits + 1;
  localparam int unsigned RemBits = tse_pkg::StopBits;

  logic [COLUMN_BITS-1:0]            column_q, column_d;
  logic [tse_pkg::ListBits-1:0]      stop_idx_q, stop_idx_d;
  logic [tse_pkg::ByteBits-1:0]      byte_q;
  logic [RemBits-1:0]                rem_q;
  logic [CntBits-1:0]                cnt_q;
  logic [tse_pkg::RepeatBits-1:0]    width_q;
  logic                              out_valid_q;
  logic [tse_pkg::ByteBits-1:0]      out_byte_q;
  logic [tse_pkg::RepeatBits-1:0]    repeat_q;

  logic [tse_pkg::ListBits-1:0]      count;
  logic [tse_pkg::StopBits-1:0]      interval;
  logic [CntBits-1:0]                bit_pos;
  logic [RemBits:0]                  rem_trial, interval_ext, rem_next;
  logic [tse_pkg::StopBits-1:0]      sel_stop;
  logic [CmpBits-1:0]                col_ext, stop_ext, stop_diff;
  logic                              search_end, search_hit;
  logic [SumBits-1:0]                col_sum;
  logic                              col_sat;
  logic                              is_tab;

  // A stop count above the table size uses the whole table.
  assign count = (list_count_i > tse_pkg::ListBits'(NUM_STOPS)) ?
                 tse_pkg::ListBits'(NUM_STOPS) : list_count_i;

  always_comb begin
    if (count == '0) begin
      interval = tse_pkg::DefaultInterval;
    end else if (stops_i[0] == '0) begin
      interval = tse_pkg::StopBits'(1);
    end else begin
      interval = stops_i[0];
    end
  end

  assign is_tab = (byte_q == tse_pkg::CharTab);

  // Restoring remainder, one column bit per cycle from the top down.
  assign bit_pos      = CntBits'(COLUMN_BITS - 1) - cnt_q;
  assign rem_trial    = {rem_q, column_q[bit_pos]};
  assign interval_ext = {1'b0, interval};
  assign rem_next     = (rem_trial >= interval_ext) ? rem_trial - interval_ext : rem_trial;

  always_comb begin
    sel_stop = '0;
    for (int i = 0; i < NUM_STOPS; i++) begin
      if (stop_idx_q == tse_pkg::ListBits'(i)) sel_stop = stops_i[i];
    end
  end

  assign col_ext    = CmpBits'(column_q);
  assign stop_ext   = CmpBits'(sel_stop);
  assign stop_diff  = stop_ext - col_ext;
  assign search_end = (stop_idx_q >= count);
  assign search_hit = !search_end && (stop_ext > col_ext);

  assign col_sum = SumBits'(column_q) + SumBits'(width_q);
  assign col_sat = |col_sum[SumBits-1:COLUMN_BITS];

  always_comb begin
    column_d   = column_q;
    stop_idx_d = stop_idx_q;
    if (cmd_i.capture && new_file_i) begin
      column_d   = '0;
      stop_idx_d = '0;
    end else if (cmd_i.search_step && !search_end && !search_hit) begin
      stop_idx_d = stop_idx_q + tse_pkg::ListBits'(1);
    end else if (cmd_i.finish) begin
      if (!is_tab && byte_q == tse_pkg::CharNl) begin
        column_d   = '0;
        stop_idx_d = '0;
      end else if (!is_tab && byte_q == tse_pkg::CharBs) begin
        if (column_q != '0) column_d = column_q - COLUMN_BITS'(1);
      end else begin
        column_d = col_sat ? '1 : col_sum[COLUMN_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      column_q    <= '0;
      stop_idx_q  <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      column_q   <= column_d;
      stop_idx_q <= stop_idx_d;
      if (cmd_i.classify) begin
        cnt_q <= '0;
      end else if (cmd_i.div_step) begin
        cnt_q <= cnt_q + CntBits'(1);
      end
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) byte_q <= in_byte_i;
    if (cmd_i.classify) begin
      rem_q   <= '0;
      width_q <= tse_pkg::RepeatBits'(1);
    end else if (cmd_i.div_step) begin
      rem_q <= rem_next[RemBits-1:0];
    end else if (cmd_i.div_fix) begin
      width_q <= interval - rem_q;
    end else if (cmd_i.search_step) begin
      if (search_hit) width_q <= stop_diff[tse_pkg::RepeatBits-1:0];
    end
    if (cmd_i.finish) begin
      out_byte_q <= is_tab ? tse_pkg::CharSpace : byte_q;
      repeat_q   <= width_q;
    end
  end

  assign status_o.is_tab       = is_tab;
  assign status_o.use_interval = (count < tse_pkg::ListBits'(2));
  assign status_o.div_last     = (cnt_q == CntBits'(COLUMN_BITS - 1));
  assign status_o.search_done  = search_end || search_hit;
  assign status_o.out_free     = !out_valid_q || out_ready_i;

  assign out_valid_o  = out_valid_q;
  assign out_byte_o   = out_byte_q;
  assign repeat_res_o = repeat_q;

endmodule

// ===== tb/sv/tab_stop_expander_tb.sv =====
// Self-checking testbench for tab_stop_expander: directed and random byte streams
// run against a behavioural column tracker under random handshake gaps.
// Depends on tse_pkg and the tab_stop_expander RTL.
module tab_stop_expander_tb;

  localparam int unsigned ColumnBits    = 16;
  localparam int unsigned NumStops      = 7;
  localparam int unsigned ColumnMax     = (1 << ColumnBits) - 1;
  localparam int unsigned WatchdogLimit = 4000;
  localparam int unsigned RandomPhases  = 12;
  localparam int unsigned PhaseBytes    = 160;

  typedef struct packed {
    logic [tse_pkg::ByteBits-1:0]   chr;
    logic [tse_pkg::RepeatBits-1:0] count;
  } emit_t;

  logic                           clk         = 1'b0;
  logic                           rst_n       = 1'b0;
  logic                           cfg_valid   = 1'b0;
  logic                           cfg_ready;
  logic [tse_pkg::CfgIdxBits-1:0] cfg_index   = '0;
  logic [tse_pkg::StopBits-1:0]   cfg_data    = '0;
  logic                           in_valid    = 1'b0;
  logic                           in_ready;
  logic [tse_pkg::ByteBits-1:0]   in_byte     = '0;
  logic                           new_file    = 1'b0;
  logic                           out_valid;
  logic                           out_ready   = 1'b0;
  logic [tse_pkg::ByteBits-1:0]   out_byte;
  logic [tse_pkg::RepeatBits-1:0] repeat_res;

  // Shadow of the block's registers and column state.
  logic [tse_pkg::ListBits-1:0] reg_list;
  logic [tse_pkg::StopBits-1:0] reg_stop [NumStops];
  int unsigned                  col_now;
  int unsigned                  stop_ptr;

  // Register values for the next load_regs call.
  logic [tse_pkg::StopBits-1:0] plan_stops [NumStops];

  emit_t       emit_q [$];
  emit_t       got;
  int unsigned n_errors    = 0;
  int unsigned idle_cycles = 0;
  int unsigned stall_left  = 0;
  int unsigned rx_gap;
  bit          gaps_on     = 1'b1;

  tab_stop_expander #(
    .COLUMN_BITS(ColumnBits),
    .NUM_STOPS  (NumStops)
  ) dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_byte_i   (in_byte),
    .new_file_i  (new_file),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_byte_o  (out_byte),
    .repeat_res_o(repeat_res)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Mostly no gap, some short ones and the odd long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (!gaps_on || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void advance_col(input int unsigned by);
    if (by > ColumnMax - col_now) col_now = ColumnMax;
    else col_now = col_now + by;
  endfunction

  // Width of the space run that takes the column to the next stop.
  function automatic int unsigned tab_run();
    int unsigned ival;
    if (reg_list < 2) begin
      ival = (reg_list == 0) ? int'(tse_pkg::DefaultInterval) : int'(reg_stop[0]);
      if (ival == 0) ival = 1;
      return ival - col_now % ival;
    end
    while (stop_ptr < reg_list) begin
      if (reg_stop[stop_ptr] > col_now) return reg_stop[stop_ptr] - col_now;
      stop_ptr++;
    end
    return 1;
  endfunction

  function automatic void expand_byte(input logic [tse_pkg::ByteBits-1:0] b, input logic nf);
    emit_t       e;
    int unsigned w;
    if (nf) begin
      col_now  = 0;
      stop_ptr = 0;
    end
    if (b == tse_pkg::CharTab) begin
      w       = tab_run();
      e.chr   = tse_pkg::CharSpace;
      e.count = w[tse_pkg::RepeatBits-1:0];
      advance_col(w);
    end else begin
      e.chr   = b;
      e.count = 1;
      if (b == tse_pkg::CharNl) begin
        col_now  = 0;
        stop_ptr = 0;
      end else if (b == tse_pkg::CharBs) begin
        if (col_now != 0) col_now--;
      end else begin
        advance_col(1);
      end
    end
    emit_q.push_back(e);
  endfunction

  // Called at a rising edge; returns at the edge where the beat is taken.
  task automatic send_byte(input logic [tse_pkg::ByteBits-1:0] b, input logic nf);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    new_file <= nf;
    do @(posedge clk); while (!in_ready);
    expand_byte(b, nf);
  endtask

  // Drop valid and hold off until every outstanding result has been taken.
  task automatic quiesce();
    in_valid <= 1'b0;
    do @(posedge clk); while (emit_q.size() != 0);
  endtask

  task automatic load_regs(input logic [tse_pkg::ListBits-1:0] lc);
    quiesce();
    for (int i = 0; i <= NumStops; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= i[tse_pkg::CfgIdxBits-1:0];
      // The upper bits of the list count beat are don't-care, so toggle them.
      if (i == tse_pkg::RegListCount) cfg_data <= {13'($urandom_range(0, 8191)), lc};
      else cfg_data <= plan_stops[i - tse_pkg::RegStop0];
      do @(posedge clk); while (!cfg_ready);
      if (i == tse_pkg::RegListCount) reg_list = lc;
      else reg_stop[i - tse_pkg::RegStop0] = plan_stops[i - tse_pkg::RegStop0];
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic test_reset_defaults();
    send_byte(tse_pkg::CharBs, 1'b0);
    send_byte("A", 1'b0);
    send_byte(tse_pkg::CharTab, 1'b0);
    send_byte(tse_pkg::CharTab, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(tse_pkg::CharBs, 1'b0);
    send_byte(tse_pkg::CharNl, 1'b0);
    send_byte(tse_pkg::CharTab, 1'b0);
    send_byte(tse_pkg::CharTab, 1'b1);
  endtask

  task automatic test_zero_interval();
    foreach (plan_stops[i]) plan_stops[i] = '0;
    load_regs(3'd1);
    send_byte(tse_pkg::CharTab, 1'b0);
    send_byte(tse_pkg::CharTab, 1'b0);
  endtask

  task automatic test_listed_stops();
    foreach (plan_stops[i]) plan_stops[i] = '0;
    plan_stops[0] = 16'd4;
    plan_stops[1] = 16'd10;
    plan_stops[2] = 16'd12;
    load_regs(3'd3);
    send_byte(tse_pkg::CharTab, 1'b1);
    send_byte("a", 1'b0);
    send_byte(tse_pkg::CharTab, 1'b0);
    send_byte(tse_pkg::CharTab, 1'b0);
    // No stop left beyond the column: a single space.
    send_byte(tse_pkg::CharTab, 1'b0);
    send_byte(tse_pkg::CharNl, 1'b0);
    send_byte(tse_pkg::CharTab, 1'b0);
  endtask

  task automatic test_column_saturation();
    foreach (plan_stops[i]) plan_stops[i] = '0;
    plan_stops[0] = 16'hffff;
    load_regs(3'd1);
    send_byte(tse_pkg::CharTab, 1'b1);
    send_byte("x", 1'b0);
    send_byte(tse_pkg::CharTab, 1'b0);
    send_byte(tse_pkg::CharBs, 1'b0);
    send_byte(tse_pkg::CharTab, 1'b0);
    foreach (plan_stops[i]) plan_stops[i] = 16'hffff;
    load_regs(3'd7);
    send_byte(tse_pkg::CharTab, 1'b1);
  endtask

  // Stops mostly ascending and close together so that lines reach them,
  // with the odd arbitrary value mixed in.
  task automatic pick_layout(input int unsigned phase,
                             output logic [tse_pkg::ListBits-1:0] lc);
    int unsigned base;
    int unsigned r;
    base = 0;
    lc   = (phase == 0) ? 3'd0 : (phase == 1) ? 3'd7 : 3'($urandom_range(0, 7));
    foreach (plan_stops[i]) begin
      if ($urandom_range(0, 9) == 0) begin
        plan_stops[i] = 16'($urandom_range(0, 65535));
      end else begin
        base          = base + $urandom_range(1, 12);
        plan_stops[i] = 16'(base);
      end
    end
    if (lc < 2) begin
      r = $urandom_range(0, 19);
      if (r == 0) plan_stops[0] = '0;
      else if (r == 1) plan_stops[0] = 16'hffff;
      else if (r == 2) plan_stops[0] = 16'($urandom_range(0, 65535));
      else plan_stops[0] = 16'($urandom_range(1, 16));
    end
  endtask

  task automatic test_random_text();
    logic [tse_pkg::ListBits-1:0] lc;
    logic [tse_pkg::ByteBits-1:0] b;
    int unsigned                  r;
    for (int p = 0; p < RandomPhases; p++) begin
      pick_layout(p, lc);
      load_regs(lc);
      gaps_on = (p % 4 != 3);
      for (int n = 0; n < PhaseBytes; n++) begin
        r = $urandom_range(0, 99);
        if (r < 25) b = tse_pkg::CharTab;
        else if (r < 33) b = tse_pkg::CharNl;
        else if (r < 39) b = tse_pkg::CharBs;
        else if (r < 85) b = 8'($urandom_range(32, 126));
        else b = 8'($urandom_range(0, 255));
        send_byte(b, $urandom_range(0, 49) == 0);
        if ($urandom_range(0, 99) == 0) quiesce();
      end
    end
    gaps_on = 1'b1;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      rx_gap = pick_gap();
      if (rx_gap == 0) begin
        out_ready <= 1'b1;
      end else begin
        out_ready  <= 1'b0;
        stall_left <= rx_gap - 1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (emit_q.size() == 0) begin
        $error("unexpected result beat: out_byte %0h repeat_res %0d", out_byte, repeat_res);
        n_errors++;
      end else begin
        got = emit_q.pop_front();
        if (out_byte !== got.chr) begin
          $error("out_byte: expected %0h, got %0h", got.chr, out_byte);
          n_errors++;
        end
        if (repeat_res !== got.count) begin
          $error("repeat_res: expected %0d, got %0d", got.count, repeat_res);
          n_errors++;
        end
      end
    end
  end

  // Ends the run if no channel moves a beat for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    reg_list = '0;
    foreach (reg_stop[i]) reg_stop[i] = '0;
    reg_stop[0] = tse_pkg::DefaultInterval;
    col_now     = 0;
    stop_ptr    = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_zero_interval();
    test_listed_stops();
    test_column_saturation();
    test_random_text();

    quiesce();
    repeat (40) @(posedge clk);
    if (n_errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
